[hw/rtl/repeated_line_filter_top_macros.svh]
// assertion macros for the repeated line filter
`ifndef REPEATED_LINE_FILTER_TOP_MACROS_SVH
`define REPEATED_LINE_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RLF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rlf assertion failed");
`define RLF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rlf assertion failed");
`else
`define RLF_ASSERT(label, clk, rst_n, prop)
`define RLF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hw/rtl/rlf_pkg.sv]
// ----------------------------------------------------------------------------
// rlf_pkg
// types and constants shared by the repeated line filter
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int LINE_BYTES = 256;
    localparam int LINE_SLOTS = 512;
    localparam int PIECE_MAX  = LINE_BYTES - 2;

    localparam int BYTE_W  = $clog2(LINE_BYTES);
    localparam int LEN_W   = BYTE_W;
    localparam int SLOT_W  = $clog2(LINE_SLOTS);
    localparam int CNT_W   = $clog2(LINE_SLOTS + 1);
    localparam int SEEN_AW = SLOT_W + BYTE_W;

    localparam int TEXT_W   = 8;
    localparam int VERDICT_W = 2;
    localparam int NUMBER_W = 9;
    localparam int PIECE_W  = 8;
    localparam logic [NUMBER_W-1:0] NUMBER_MAX = 9'd511;

    typedef enum logic [VERDICT_W-1:0] {
        V_FIRST  = 2'd0,
        V_REPEAT = 2'd1,
        V_FULL   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [TEXT_W-1:0] wdata;
        logic [BYTE_W-1:0] raddr;
    } t_piece_req;

    typedef struct packed {
        logic               we;
        logic [SEEN_AW-1:0] waddr;
        logic [TEXT_W-1:0]  wdata;
        logic [SEEN_AW-1:0] raddr;
    } t_seen_req;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [LEN_W-1:0]  wdata;
        logic [SLOT_W-1:0] raddr;
    } t_slen_req;

endpackage

[hw/rtl/rlf_if.sv]
// ----------------------------------------------------------------------------
// rlf_in_if / rlf_out_if
// valid/ready channels for text bytes and per-piece verdicts
// ----------------------------------------------------------------------------
interface rlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;
    logic       file_start;

    modport source (output valid, output text_byte, output line_end, output file_start,
                    input ready);
    modport sink (input valid, input text_byte, input line_end, input file_start,
                  output ready);
endinterface

interface rlf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [8:0] line_number;
    logic [7:0] piece_length;

    modport source (output valid, output verdict, output line_number, output piece_length,
                    input ready);
    modport sink (input valid, input verdict, input line_number, input piece_length,
                  output ready);
endinterface

[hw/rtl/rlf_ram.sv]
// ----------------------------------------------------------------------------
// rlf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rlf_ctrl.sv]
// ----------------------------------------------------------------------------
// rlf_ctrl
// gathers piece bytes, walks the seen store and issues one verdict per piece
// ----------------------------------------------------------------------------
`include "repeated_line_filter_top_macros.svh"

module rlf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_line_end,
    input  logic                   i_file_start,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_verdict,
    output logic [8:0]             o_line_number,
    output logic [7:0]             o_piece_length,
    output rlf_pkg::t_piece_req    o_piece_req,
    input  logic [7:0]             i_piece_rdata,
    output rlf_pkg::t_seen_req     o_seen_req,
    input  logic [7:0]             i_seen_rdata,
    output rlf_pkg::t_slen_req     o_slen_req,
    input  logic [rlf_pkg::LEN_W-1:0] i_slen_rdata
);
    import rlf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LEN_RD, S_LEN_CHK, S_BYTES, S_COPY, S_RESULT
    } t_state;

    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [NUMBER_W-1:0]  r_pc, n_pc;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [LEN_W-1:0]     r_j, n_j;
    logic [LEN_W-1:0]     r_jd, n_jd;
    logic                 r_chk, n_chk;
    t_verdict             r_verdict, n_verdict;
    logic                 r_out_vld, n_out_vld;
    logic [VERDICT_W-1:0] r_out_verdict, n_out_verdict;
    logic [NUMBER_W-1:0]  r_out_num, n_out_num;
    logic [PIECE_W-1:0]   r_out_len, n_out_len;

    logic             accept;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] new_len;
    logic [CNT_W-1:0] eff_count;
    logic             last_entry;
    logic             mism;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign eff_len    = i_file_start ? '0 : r_len;
    assign new_len    = eff_len + LEN_W'(1);
    assign eff_count  = i_file_start ? '0 : r_count;
    assign last_entry = (r_k + CNT_W'(1)) == r_count;
    assign mism       = r_chk && (i_piece_rdata != i_seen_rdata);

    always_comb begin
        o_piece_req.we    = accept;
        o_piece_req.waddr = eff_len[BYTE_W-1:0];
        o_piece_req.wdata = i_text_byte;
        o_piece_req.raddr = r_j[BYTE_W-1:0];
        o_seen_req.we     = (r_state == S_COPY) && r_chk;
        o_seen_req.waddr  = {r_count[SLOT_W-1:0], r_jd[BYTE_W-1:0]};
        o_seen_req.wdata  = i_piece_rdata;
        o_seen_req.raddr  = {r_k[SLOT_W-1:0], r_j[BYTE_W-1:0]};
        o_slen_req.we     = (r_state == S_COPY) && r_chk && (r_j == r_len);
        o_slen_req.waddr  = r_count[SLOT_W-1:0];
        o_slen_req.wdata  = r_len;
        o_slen_req.raddr  = r_k[SLOT_W-1:0];
    end

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_count       = r_count;
        n_pc          = r_pc;
        n_k           = r_k;
        n_j           = r_j;
        n_jd          = r_jd;
        n_chk         = r_chk;
        n_verdict     = r_verdict;
        n_out_vld     = r_out_vld && !i_out_ready;
        n_out_verdict = r_out_verdict;
        n_out_num     = r_out_num;
        n_out_len     = r_out_len;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_len = new_len;
                    n_count = eff_count;
                    if (i_file_start) begin
                        n_pc = '0;
                    end
                    if (i_line_end || new_len == LEN_W'(PIECE_MAX)) begin
                        n_k   = '0;
                        n_j   = '0;
                        n_chk = 1'b0;
                        // empty store: straight to storing
                        n_state = (eff_count == '0) ? S_COPY : S_LEN_RD;
                    end
                end
            end
            S_LEN_RD: begin
                n_state = S_LEN_CHK;
            end
            S_LEN_CHK, S_BYTES: begin
                if ((r_state == S_LEN_CHK && i_slen_rdata != r_len) ||
                    (r_state == S_BYTES && mism)) begin
                    n_chk = 1'b0;
                    n_j   = '0;
                    if (last_entry) begin
                        if (r_count < CNT_W'(LINE_SLOTS)) begin
                            n_state = S_COPY;
                        end else begin
                            n_verdict = V_FULL;
                            n_state   = S_RESULT;
                        end
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_LEN_RD;
                    end
                end else if (r_state == S_LEN_CHK) begin
                    n_j     = '0;
                    n_chk   = 1'b0;
                    n_state = S_BYTES;
                end else if (r_j == r_len) begin
                    n_verdict = V_REPEAT;
                    n_state   = S_RESULT;
                end else begin
                    n_j   = r_j + LEN_W'(1);
                    n_chk = 1'b1;
                end
            end
            S_COPY: begin
                if (r_j == r_len) begin
                    n_count   = r_count + CNT_W'(1);
                    n_verdict = V_FIRST;
                    n_chk     = 1'b0;
                    n_state   = S_RESULT;
                end else begin
                    n_jd  = r_j;
                    n_j   = r_j + LEN_W'(1);
                    n_chk = 1'b1;
                end
            end
            S_RESULT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld     = 1'b1;
                    n_out_verdict = r_verdict;
                    n_out_num     = r_pc;
                    n_out_len     = PIECE_W'(r_len);
                    if (r_pc < NUMBER_MAX) begin
                        n_pc = r_pc + NUMBER_W'(1);
                    end
                    n_len   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_count   <= '0;
            r_pc      <= '0;
            r_chk     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_count   <= n_count;
            r_pc      <= n_pc;
            r_chk     <= n_chk;
            r_out_vld <= n_out_vld;
        end
        r_k           <= n_k;
        r_j           <= n_j;
        r_jd          <= n_jd;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
        r_out_num     <= n_out_num;
        r_out_len     <= n_out_len;
    end

    assign o_out_valid    = r_out_vld;
    assign o_verdict      = r_out_verdict;
    assign o_line_number  = r_out_num;
    assign o_piece_length = r_out_len;

    `RLF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(LINE_SLOTS))
    `RLF_ASSERT(a_store_room, i_clk, i_rst_n, o_seen_req.we |-> r_count < CNT_W'(LINE_SLOTS))
    `RLF_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= LEN_W'(PIECE_MAX))
    `RLF_ASSERT(a_result_src, i_clk, i_rst_n,
        $rose(r_out_vld) |-> $past(r_state == S_RESULT))

endmodule

[hw/rtl/repeated_line_filter_top.sv]
// ----------------------------------------------------------------------------
// repeated_line_filter_top
// marks each line piece as first occurrence, repeat or store full
// ----------------------------------------------------------------------------
// a byte that ends no piece is written to the piece buffer; input stays ready
// at a piece end each stored piece is checked on length, and byte by byte if
// lengths match; a new piece is copied if there is room, then a result issued
// the seen store memory port walks entries one byte per cycle
// reset clears state, counters and flags only; the memories need no clearing pass
module repeated_line_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlf_in_if.sink      i_text,
    rlf_out_if.source   o_res
);
    import rlf_pkg::*;

    t_piece_req       piece_req;
    t_seen_req        seen_req;
    t_slen_req        slen_req;
    logic [7:0]       piece_rdata;
    logic [7:0]       seen_rdata;
    logic [LEN_W-1:0] slen_rdata;

    rlf_ram #(.WIDTH(TEXT_W), .DEPTH(LINE_BYTES)) u_piece_ram (
        .i_clk   (i_clk),
        .i_we    (piece_req.we),
        .i_waddr (piece_req.waddr),
        .i_wdata (piece_req.wdata),
        .i_raddr (piece_req.raddr),
        .o_rdata (piece_rdata)
    );

    rlf_ram #(.WIDTH(TEXT_W), .DEPTH(LINE_SLOTS * LINE_BYTES)) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (seen_req.we),
        .i_waddr (seen_req.waddr),
        .i_wdata (seen_req.wdata),
        .i_raddr (seen_req.raddr),
        .o_rdata (seen_rdata)
    );

    rlf_ram #(.WIDTH(LEN_W), .DEPTH(LINE_SLOTS)) u_slen_ram (
        .i_clk   (i_clk),
        .i_we    (slen_req.we),
        .i_waddr (slen_req.waddr),
        .i_wdata (slen_req.wdata),
        .i_raddr (slen_req.raddr),
        .o_rdata (slen_rdata)
    );

    rlf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_text.valid),
        .o_in_ready     (i_text.ready),
        .i_text_byte    (i_text.text_byte),
        .i_line_end     (i_text.line_end),
        .i_file_start   (i_text.file_start),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_verdict      (o_res.verdict),
        .o_line_number  (o_res.line_number),
        .o_piece_length (o_res.piece_length),
        .o_piece_req    (piece_req),
        .i_piece_rdata  (piece_rdata),
        .o_seen_req     (seen_req),
        .i_seen_rdata   (seen_rdata),
        .o_slen_req     (slen_req),
        .i_slen_rdata   (slen_rdata)
    );

endmodule
